// ----- hdl/tks_pkg.sv -----
// Package for the top-K smallest record selector.
// Holds item structs, field widths, defaults and the control interface types.
// No dependencies.
package tks_pkg;

    localparam int KeepCountDef = 10;
    localparam int TagWidthDef  = 10;

    localparam int HeightW = 16;
    localparam int NameW   = 64;
    localparam int TagW    = 10;

    typedef struct packed {
        logic [HeightW-1:0] height_centi;
        logic [NameW-1:0]   name_key;
        logic [TagW-1:0]    record_tag;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic [TagW-1:0]    out_tag;
        logic [HeightW-1:0] out_height;
        logic [NameW-1:0]   out_name_key;
        logic               out_last;
    } t_out_item;

    typedef struct packed {
        logic insert;
        logic emit;
    } t_tks_cmd;

    typedef struct packed {
        logic count_is_one;
    } t_tks_status;

endpackage

// ----- hdl/tks_datapath.sv -----
// Datapath of the top-K selector: a sorted insertion chain of cells,
// the fill count and the result register. Depends on tks_pkg.
module tks_datapath
    import tks_pkg::*;
#(
    parameter int KEEP_COUNT = KeepCountDef,
    parameter int TAG_WIDTH  = TagWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tks_cmd    i_cmd,
    input  t_in_item    i_in_item,
    output t_tks_status o_status,
    output t_out_item   o_out_item
);

    localparam int CntW = $clog2(KEEP_COUNT + 1);

    logic [HeightW-1:0]   r_height [KEEP_COUNT];
    logic [NameW-1:0]     r_name   [KEEP_COUNT];
    logic [TAG_WIDTH-1:0] r_tag    [KEEP_COUNT];
    logic [CntW-1:0]      r_count;
    t_out_item            r_out_item;

    logic [KEEP_COUNT-1:0] goes_here;
    logic [TAG_WIDTH-1:0]  new_tag;

    assign new_tag = TAG_WIDTH'(i_in_item.record_tag);

    // A cell is marked when the new item belongs at or before it.
    always_comb begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            goes_here[i] = (CntW'(i) >= r_count)
                || (i_in_item.height_centi < r_height[i])
                || ((i_in_item.height_centi == r_height[i])
                    && (i_in_item.name_key < r_name[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int i = 0; i < KEEP_COUNT; i++) begin
                if (goes_here[i]) begin
                    if (i > 0 && goes_here[(i > 0) ? i - 1 : 0]) begin
                        r_height[i] <= r_height[(i > 0) ? i - 1 : 0];
                        r_name[i]   <= r_name[(i > 0) ? i - 1 : 0];
                        r_tag[i]    <= r_tag[(i > 0) ? i - 1 : 0];
                    end else begin
                        r_height[i] <= i_in_item.height_centi;
                        r_name[i]   <= i_in_item.name_key;
                        r_tag[i]    <= new_tag;
                    end
                end
            end
        end else if (i_cmd.emit) begin
            for (int i = 0; i < KEEP_COUNT - 1; i++) begin
                r_height[i] <= r_height[i + 1];
                r_name[i]   <= r_name[i + 1];
                r_tag[i]    <= r_tag[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            if (r_count < CntW'(KEEP_COUNT)) begin
                r_count <= r_count + CntW'(1);
            end
        end else if (i_cmd.emit) begin
            r_count <= r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.out_tag      <= TagW'(r_tag[0]);
            r_out_item.out_height   <= r_height[0];
            r_out_item.out_name_key <= r_name[0];
            r_out_item.out_last     <= (r_count == CntW'(1));
        end
    end

    assign o_status.count_is_one = (r_count == CntW'(1));
    assign o_out_item            = r_out_item;

endmodule

// ----- hdl/tks_ctrl.sv -----
// Controller of the top-K selector: collects items, then drains the
// chain into the result register. Depends on tks_pkg.
module tks_ctrl
    import tks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_last,
    output logic        o_in_stall,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_tks_status i_status,
    output t_tks_cmd    o_cmd
);

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;
    logic   in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_take    = (r_state == ST_COLLECT) && i_in_valid;
    assign o_in_stall = (r_state != ST_COLLECT);

    assign o_cmd.insert = in_take;
    assign o_cmd.emit   = (r_state == ST_EMIT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_COLLECT: begin
                    if (in_take && i_in_last) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (o_cmd.emit && i_status.count_is_one) begin
                        r_state <= ST_COLLECT;
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/top_k_smallest_selector.sv -----
// Top-K smallest selector: keeps the KEEP_COUNT smallest items by (height, name key).
// Results: the first result is registered once the last-marked item is taken and the
// emit state is entered, then one result per cycle when not stalled.
// Throughput: one item per cycle while collecting; input is stalled while the
// min(count, KEEP_COUNT) results drain from the sorted cell chain.
// Reset: synchronous active-low reset empties the kept set and clears valid.
module top_k_smallest_selector
    import tks_pkg::*;
#(
    parameter int KEEP_COUNT = KeepCountDef,
    parameter int TAG_WIDTH  = TagWidthDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_tks_cmd    cmd;
    t_tks_status status;

    tks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_item.last_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tks_datapath #(
        .KEEP_COUNT (KEEP_COUNT),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

// ----- verif/tb_top_k_smallest_selector.sv -----
// Testbench for top_k_smallest_selector: streams record sets into the block and checks
// every emitted record against a sorted-set predictor kept in the testbench.
// Depends on tks_pkg and the top_k_smallest_selector RTL.
module tb_top_k_smallest_selector;
    import tks_pkg::*;

    localparam int KEEP = KeepCountDef;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 430;

    typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_RARE, STALL_BLOCKS} t_stall_mode;
    typedef enum logic [1:0] {KEYS_WIDE, KEYS_CLUSTERED, KEYS_EDGES} t_key_spread;

    typedef struct packed {
        logic     hold_idle;
        t_in_item rec;
    } t_feed_entry;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    t_feed_entry record_feed[$];
    t_out_item   expected_sorted[$];

    logic [HeightW-1:0] kept_height[KEEP];
    logic [NameW-1:0]   kept_name[KEEP];
    logic [TagW-1:0]    kept_tag[KEEP];
    int                 kept_total = 0;

    int          mismatches = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          burst_left = 1;
    t_feed_entry next_entry;
    t_out_item   want;
    logic [5:0]  stall_phase;
    t_stall_mode stall_mode;

    top_k_smallest_selector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit orders_below(logic [HeightW-1:0] ha, logic [NameW-1:0] na,
                                        logic [HeightW-1:0] hb, logic [NameW-1:0] nb);
        return (ha < hb) || (ha == hb && na < nb);
    endfunction

    // Inserts one record into the sorted kept set and, on a last mark, queues the set.
    function automatic void take_record(t_in_item it);
        int        pos;
        bit        place;
        t_out_item res;
        pos = 0;
        place = 1'b0;
        if (kept_total < KEEP) begin
            pos = kept_total;
            kept_total++;
            place = 1'b1;
        end else if (orders_below(it.height_centi, it.name_key,
                                  kept_height[KEEP-1], kept_name[KEEP-1])) begin
            pos = KEEP - 1;
            place = 1'b1;
        end
        if (place) begin
            while (pos > 0 && orders_below(it.height_centi, it.name_key,
                                           kept_height[pos-1], kept_name[pos-1])) begin
                kept_height[pos] = kept_height[pos-1];
                kept_name[pos]   = kept_name[pos-1];
                kept_tag[pos]    = kept_tag[pos-1];
                pos--;
            end
            kept_height[pos] = it.height_centi;
            kept_name[pos]   = it.name_key;
            kept_tag[pos]    = it.record_tag;
        end
        if (it.last_item) begin
            for (int k = 0; k < kept_total; k++) begin
                res.out_tag      = kept_tag[k];
                res.out_height   = kept_height[k];
                res.out_name_key = kept_name[k];
                res.out_last     = (k + 1 == kept_total);
                expected_sorted.push_back(res);
            end
            kept_total = 0;
        end
    endfunction

    function automatic void queue_record(logic [HeightW-1:0] h, logic [NameW-1:0] n,
                                         logic [TagW-1:0] tag, logic last, logic hold);
        t_feed_entry e;
        e.hold_idle       = hold;
        e.rec.height_centi = h;
        e.rec.name_key     = n;
        e.rec.record_tag   = tag;
        e.rec.last_item    = last;
        record_feed.push_back(e);
    endfunction

    function automatic t_in_item random_record(t_key_spread spread, logic last);
        t_in_item r;
        r.record_tag = TagW'($urandom_range(0, 1023));
        r.last_item  = last;
        case (spread)
            KEYS_CLUSTERED: begin
                r.height_centi = HeightW'($urandom_range(0, 3));
                r.name_key     = NameW'($urandom_range(0, 2));
            end
            KEYS_EDGES: begin
                if ($urandom_range(0, 1) != 0) begin
                    r.height_centi = 16'hFFFF - HeightW'($urandom_range(0, 2));
                end else begin
                    r.height_centi = HeightW'($urandom_range(0, 2));
                end
                case ($urandom_range(0, 2))
                    0: r.name_key = 64'hFFFF_FFFF_FFFF_FFFF;
                    1: r.name_key = 64'h0;
                    default: r.name_key = {$urandom, $urandom};
                endcase
            end
            default: begin
                r.height_centi = HeightW'($urandom);
                r.name_key     = {$urandom, $urandom};
            end
        endcase
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                take_record(in_item);
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end else if (record_feed.size() > 0 &&
                             (!record_feed[0].hold_idle || expected_sorted.size() == 0)) begin
                    next_entry = record_feed.pop_front();
                    in_item  <= next_entry.rec;
                    in_valid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0) begin
                            gap_left = $urandom_range(0, 12);
                        end else begin
                            gap_left = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 2);
                        end
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, changing its mode whenever the 6-bit phase counter wraps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall   <= 1'b0;
            stall_phase <= '0;
            stall_mode  <= STALL_NONE;
        end else begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase == 6'd63) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
            end
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_HALF:   out_stall <= ($urandom_range(0, 1) != 0);
                STALL_RARE:   out_stall <= ($urandom_range(0, 4) == 0);
                default:      out_stall <= (stall_phase[3:0] < 4'd7);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_sorted.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual %p", $time, o_out_item);
                mismatches++;
            end else begin
                want = expected_sorted.pop_front();
                if (o_out_item.out_tag !== want.out_tag) begin
                    $display("%0t: out_tag expected %0d actual %0d",
                             $time, want.out_tag, o_out_item.out_tag);
                    mismatches++;
                end
                if (o_out_item.out_height !== want.out_height) begin
                    $display("%0t: out_height expected %0d actual %0d",
                             $time, want.out_height, o_out_item.out_height);
                    mismatches++;
                end
                if (o_out_item.out_name_key !== want.out_name_key) begin
                    $display("%0t: out_name_key expected %h actual %h",
                             $time, want.out_name_key, o_out_item.out_name_key);
                    mismatches++;
                end
                if (o_out_item.out_last !== want.out_last) begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.out_last, o_out_item.out_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("** top_k_smallest_selector: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int          queued;
        int          set_size;
        t_key_spread spread;
        t_in_item    r;

        queue_record(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 1'b1, 1'b1);
        queue_record(16'h0, 64'h0, 10'h0, 1'b1, 1'b0);
        // Ties keep arrival order; a full set drops equal and larger keys and
        // displaces the last-arrived of several equal largest records.
        for (int i = 0; i < 5; i++) queue_record(16'd100, 64'd7, 10'(i), 1'b0, 1'b0);
        for (int i = 0; i < 5; i++) queue_record(16'd200, 64'd3, 10'(10 + i), 1'b0, 1'b0);
        queue_record(16'd200, 64'd3, 10'd20, 1'b0, 1'b0);
        queue_record(16'd150, 64'd9, 10'd21, 1'b0, 1'b0);
        queue_record(16'd0, 64'd0, 10'd22, 1'b0, 1'b0);
        queue_record(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'd23, 1'b1, 1'b0);
        queue_record(16'd300, 64'h0100_0000_0000_0000, 10'd30, 1'b0, 1'b1);
        queue_record(16'd300, 64'h0000_0000_0000_00FF, 10'd31, 1'b0, 1'b0);
        queue_record(16'd300, 64'h8000_0000_0000_0000, 10'd32, 1'b0, 1'b0);
        queue_record(16'd299, 64'hFFFF_FFFF_FFFF_FFFF, 10'd33, 1'b1, 1'b0);

        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                set_size = $urandom_range(1, 12);
            end else begin
                set_size = $urandom_range(11, 28);
            end
            spread = t_key_spread'($urandom_range(0, 2));
            for (int i = 0; i < set_size; i++) begin
                r = random_record(spread, i == set_size - 1);
                queue_record(r.height_centi, r.name_key, r.record_tag, r.last_item,
                             i == 0 && $urandom_range(0, 7) == 0);
            end
            queued += set_size;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (record_feed.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_sorted.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** top_k_smallest_selector: PASSED **");
        end else begin
            $display("** top_k_smallest_selector: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tks_pkg.sv
hdl/tks_datapath.sv
hdl/tks_ctrl.sv
hdl/top_k_smallest_selector.sv
verif/tb_top_k_smallest_selector.sv
